@@ rtl/lfbr_pkg.sv @@
// Shared widths, operation codes and controller command type for the lazy fill byte RAM.
package lfbr_pkg;

    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 4;
    localparam int DATA_W  = 64;
    localparam int LANES   = 8;
    localparam int LANE_W  = 3;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

    localparam logic [SIZE_W-1:0] MAX_SIZE = 4'd8;

    typedef struct packed {
        logic accept;     // request word taken this cycle
        logic wr_hi;      // write the upper of the two touched words
        logic load_out;   // merge read data into the output register
        logic clr_step;   // clear one row of written marks
    } ctrl_cmd_t;

endpackage

@@ rtl/lfbr_if.sv @@
// Request and response channel interfaces of the lazy fill byte RAM.
interface lfbr_req_if;
    import lfbr_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] access_size;
    logic [DATA_W-1:0] write_value;

    modport source (output valid, output func, output address, output access_size,
                    output write_value, input ready);
    modport sink (input valid, input func, input address, input access_size,
                  input write_value, output ready);
endinterface

interface lfbr_rsp_if;
    import lfbr_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

@@ rtl/lfbr_ctrl.sv @@
// Controller state machine: request sequencing, mark clearing pass and output valid.
module lfbr_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [lfbr_pkg::FUNC_W-1:0] in_func,
    output logic                      in_ready,
    input  logic                      out_ready,
    output logic                      out_valid,
    input  logic                      clr_last,
    output lfbr_pkg::ctrl_cmd_t       cmd
);
    import lfbr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WR_HI
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.wr_hi    = (state_reg == ST_WR_HI);
        cmd.load_out = (state_reg == ST_READ) && out_free;
        cmd.clr_step = (state_reg == ST_CLEAR);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_func)
                        FUNC_READ:  state_next = ST_READ;
                        FUNC_WRITE: state_next = ST_WR_HI;
                        FUNC_INIT:  state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR_HI:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Reset starts in the clearing pass so every written mark begins at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/lfbr_datapath.sv @@
// Datapath: data and mark memories, byte lane alignment, fill pattern and read merge.
module lfbr_datapath #(
    parameter int ADDR_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfbr_pkg::ctrl_cmd_t         cmd,
    input  logic [lfbr_pkg::FUNC_W-1:0] func,
    input  logic [lfbr_pkg::ADDR_W-1:0] address,
    input  logic [lfbr_pkg::SIZE_W-1:0] access_size,
    input  logic [lfbr_pkg::DATA_W-1:0] write_value,
    output logic [lfbr_pkg::DATA_W-1:0] read_data,
    output logic                        clr_last
);
    import lfbr_pkg::*;

    localparam int WORD_BITS = ADDR_BITS - LANE_W;
    localparam longint unsigned WORDS = 64'd1 << WORD_BITS;

    logic [DATA_W-1:0] data_ram [0:WORDS-1];
    logic [LANES-1:0]  mark_ram [0:WORDS-1];

    logic [ADDR_BITS+ADDR_W-1:0] addr_ext;
    logic [ADDR_BITS-1:0]        byte_addr;
    logic [WORD_BITS-1:0]        word_lo;
    logic [WORD_BITS-1:0]        word_hi;
    logic [LANE_W-1:0]           lane_off;
    logic                        size_ok;
    logic [2*LANES-1:0]          size_mask;
    logic [2*LANES-1:0]          wr_en16;
    logic [2*DATA_W-1:0]         wr_shift;
    logic                        wr_lo;
    logic                        rd_issue;

    logic [WORD_BITS-1:0] hi_addr_reg;
    logic [DATA_W-1:0]    hi_data_reg;
    logic [LANES-1:0]     hi_en_reg;
    logic [LANE_W-1:0]    off_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [DATA_W-1:0]    fill_reg;
    logic [WORD_BITS-1:0] clr_addr_reg;
    logic [DATA_W-1:0]    rd_lo_reg;
    logic [DATA_W-1:0]    rd_hi_reg;
    logic [LANES-1:0]     mk_lo_reg;
    logic [LANES-1:0]     mk_hi_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic [DATA_W-1:0]    merge_next;

    logic                 data_we;
    logic [WORD_BITS-1:0] data_waddr;
    logic [LANES-1:0]     data_be;
    logic [DATA_W-1:0]    data_wd;
    logic                 mark_we;
    logic [WORD_BITS-1:0] mark_waddr;
    logic [LANES-1:0]     mark_mask;
    logic [LANES-1:0]     mark_wd;

    // The input address is fitted to the memory size, then split into word and lane.
    assign addr_ext  = {{ADDR_BITS{1'b0}}, address};
    assign byte_addr = addr_ext[ADDR_BITS-1:0];
    assign word_lo   = byte_addr[ADDR_BITS-1:LANE_W];
    assign word_hi   = word_lo + 1'b1;
    assign lane_off  = byte_addr[LANE_W-1:0];

    assign size_ok   = (access_size <= MAX_SIZE);
    assign size_mask = (16'd1 << access_size) - 16'd1;
    assign wr_lo     = cmd.accept && (func == FUNC_WRITE);
    assign rd_issue  = cmd.accept && (func == FUNC_READ);
    assign wr_en16   = (wr_lo && size_ok) ? (size_mask << lane_off) : '0;
    assign wr_shift  = {{DATA_W{1'b0}}, write_value} << {lane_off, 3'b000};
    assign clr_last  = (clr_addr_reg == {WORD_BITS{1'b1}});

    always_comb
    begin
        data_we    = 1'b0;
        data_waddr = word_lo;
        data_be    = wr_en16[LANES-1:0];
        data_wd    = wr_shift[DATA_W-1:0];
        mark_we    = 1'b0;
        mark_waddr = word_lo;
        mark_mask  = wr_en16[LANES-1:0];
        mark_wd    = '1;
        if (cmd.clr_step)
        begin
            mark_we    = 1'b1;
            mark_waddr = clr_addr_reg;
            mark_mask  = '1;
            mark_wd    = '0;
        end
        else if (cmd.wr_hi)
        begin
            data_we    = 1'b1;
            data_waddr = hi_addr_reg;
            data_be    = hi_en_reg;
            data_wd    = hi_data_reg;
            mark_we    = 1'b1;
            mark_waddr = hi_addr_reg;
            mark_mask  = hi_en_reg;
        end
        else if (wr_lo)
        begin
            data_we = 1'b1;
            mark_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (data_be[l])
                begin
                    data_ram[data_waddr][8*l +: 8] <= data_wd[8*l +: 8];
                end
            end
        end
        if (mark_we)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (mark_mask[l])
                begin
                    mark_ram[mark_waddr][l] <= mark_wd[l];
                end
            end
        end
        if (rd_issue)
        begin
            rd_lo_reg <= data_ram[word_lo];
            rd_hi_reg <= data_ram[word_hi];
            mk_lo_reg <= mark_ram[word_lo];
            mk_hi_reg <= mark_ram[word_hi];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hi_addr_reg <= word_hi;
            hi_data_reg <= wr_shift[2*DATA_W-1:DATA_W];
            hi_en_reg   <= wr_en16[2*LANES-1:LANES];
            off_reg     <= lane_off;
            size_reg    <= access_size;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= merge_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.accept && (func == FUNC_INIT))
            begin
                fill_reg <= write_value;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Byte i of the result comes from position offset+i of the two words; an
    // unmarked byte takes the fill pattern byte of its lane instead.
    always_comb
    begin
        logic [2*DATA_W-1:0] pair;
        logic [2*LANES-1:0]  marks;
        logic [3:0]          pos;
        pair       = {rd_hi_reg, rd_lo_reg};
        marks      = {mk_hi_reg, mk_lo_reg};
        merge_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            pos = {1'b0, off_reg} + 4'(i);
            if ((4'(i) < size_reg) && (size_reg <= MAX_SIZE))
            begin
                if (marks[pos])
                begin
                    merge_next[8*i +: 8] = pair[8*pos +: 8];
                end
                else
                begin
                    merge_next[8*i +: 8] = fill_reg[8*pos[LANE_W-1:0] +: 8];
                end
            end
        end
    end

    assign read_data = out_data_reg;

endmodule

@@ rtl/lazy_fill_byte_ram.sv @@
// Top level of the lazy fill byte RAM: controller and datapath on two word channels.
//
//  channel | dir | payload                                   | handshake
//  req     | in  | func, address, access_size, write_value   | valid/ready
//  rsp     | out | read_data (one word per read request)     | valid/ready
//
// A read fetches both touched words in the accept cycle and merges them into
// the output register in the read state once that register is free. A write
// stores one touched word per step, the lower on accept, the upper in the
// write-high state, set by the single write port of the data and mark memories.
// Init clears the written marks one row a cycle. The same clearing pass runs
// after reset, with ready low. While a response word waits, a following read
// stays in its merge cycle with ready low until that word is taken.
module lazy_fill_byte_ram #(
    parameter int ADDR_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    lfbr_req_if.sink    req,
    lfbr_rsp_if.source  rsp
);
    import lfbr_pkg::*;

    ctrl_cmd_t cmd;
    logic      clr_last;

    lfbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .clr_last  (clr_last),
        .cmd       (cmd)
    );

    lfbr_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (req.func),
        .address     (req.address),
        .access_size (req.access_size),
        .write_value (req.write_value),
        .read_data   (rsp.read_data),
        .clr_last    (clr_last)
    );

endmodule
